### sv/motor_stop_supervisor_defines.svh
// Assertion macros shared by the supervisor RTL.
`ifndef MOTOR_STOP_SUPERVISOR_DEFINES_SVH
`define MOTOR_STOP_SUPERVISOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MSS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/mss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mss_pkg;

    localparam int unsigned TIMEOUT_W = 5;
    localparam int unsigned TICKS_W   = 5;

    localparam logic [1:0] OP_START      = 2'd0;
    localparam logic [1:0] OP_STOP       = 2'd1;
    localparam logic [1:0] OP_STOP_CAUSE = 2'd2;
    localparam logic [1:0] OP_TICK       = 2'd3;

    localparam logic [2:0] EV_NONE          = 3'd0;
    localparam logic [2:0] EV_RUN           = 3'd1;
    localparam logic [2:0] EV_STOPPING      = 3'd2;
    localparam logic [2:0] EV_PAUSE         = 3'd3;
    localparam logic [2:0] EV_STOP          = 3'd4;
    localparam logic [2:0] EV_MOTOR_STOPPED = 3'd5;

    localparam logic [1:0] MODE_RUN     = 2'd0;
    localparam logic [1:0] MODE_STOPPED = 2'd1;
    localparam logic [1:0] MODE_PAUSED  = 2'd2;
    localparam logic [1:0] MODE_NEVER   = 2'd3;

    localparam logic [TICKS_W-1:0]   TICKS_MAX       = 5'd31;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET   = 5'd20;
    localparam logic [3:0]           CAUSE_USER      = 4'd0;
    localparam logic signed [15:0]   ALARM_AFTER_START = -16'sd1;

    typedef struct packed {
        logic [1:0]         op;
        logic               move_backward;
        logic signed [31:0] expected_count_in;
        logic               target_pause;
        logic [3:0]         cause_in;
        logic signed [15:0] alarm_in;
        logic [31:0]        encoder_count;
    } req_item_t;

    typedef struct packed {
        logic [1:0]         mode;
        logic               stopping;
        logic               direction;
        logic signed [31:0] expected;
        logic [3:0]         cause;
        logic signed [15:0] alarm;
        logic [31:0]        last_sample;
        logic               pending_pause;
        logic [TICKS_W-1:0] ticks;
        logic               power;
        logic               encoder;
    } state_t;

    typedef struct packed {
        logic [2:0] first_event;
        logic       two_results;
        logic       clear_encoder;
    } step_res_t;

endpackage

`default_nettype wire

### sv/mss_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mss_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic               move_backward;
    logic signed [31:0] expected_count_in;
    logic               target_pause;
    logic [3:0]         cause_in;
    logic signed [15:0] alarm_in;
    logic [31:0]        encoder_count;

    modport source (
        output valid, op, move_backward, expected_count_in, target_pause,
               cause_in, alarm_in, encoder_count,
        input  ready
    );
    modport sink (
        input  valid, op, move_backward, expected_count_in, target_pause,
               cause_in, alarm_in, encoder_count,
        output ready
    );
endinterface

`default_nettype wire

### sv/mss_res_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mss_res_if;
    logic               valid;
    logic               ready;
    logic [2:0]         event_res;
    logic               last;
    logic               motor_power;
    logic               encoder_enable;
    logic               clear_encoder;
    logic [1:0]         motor_mode;
    logic               is_stopping;
    logic               direction_out;
    logic signed [31:0] expected_count;
    logic [3:0]         stop_cause;
    logic signed [15:0] alarm_detail;

    modport source (
        output valid, event_res, last, motor_power, encoder_enable, clear_encoder,
               motor_mode, is_stopping, direction_out, expected_count, stop_cause,
               alarm_detail,
        input  ready
    );
    modport sink (
        input  valid, event_res, last, motor_power, encoder_enable, clear_encoder,
               motor_mode, is_stopping, direction_out, expected_count, stop_cause,
               alarm_detail,
        output ready
    );
endinterface

`default_nettype wire

### sv/mss_step.sv
`timescale 1ns / 1ps
`default_nettype none

module mss_step
    import mss_pkg::*;
(
    input  state_t               st,
    input  req_item_t            item,
    input  logic [TIMEOUT_W-1:0] timeout,
    output state_t               st_next,
    output step_res_t            res
);

    logic [1:0]         target;
    logic [TICKS_W-1:0] ticks_inc;
    logic               done;

    always_comb
    begin
        st_next   = st;
        res       = '{first_event: EV_NONE, two_results: 1'b0, clear_encoder: 1'b0};
        target    = item.target_pause ? MODE_PAUSED : MODE_STOPPED;
        ticks_inc = (st.ticks < TICKS_MAX) ? st.ticks + 1'b1 : st.ticks;
        done      = 1'b0;

        case (item.op)
            OP_START:
            begin
                if (st.mode != MODE_RUN || st.stopping)
                begin
                    res.first_event = EV_RUN;
                end
                res.clear_encoder = 1'b1;
                st_next.stopping  = 1'b0;
                st_next.ticks     = '0;
                st_next.expected  = item.expected_count_in;
                st_next.direction = item.move_backward;
                st_next.mode      = MODE_RUN;
                st_next.cause     = CAUSE_USER;
                st_next.alarm     = ALARM_AFTER_START;
                st_next.power     = 1'b1;
                st_next.encoder   = 1'b1;
            end
            OP_STOP, OP_STOP_CAUSE:
            begin
                if (item.op == OP_STOP_CAUSE)
                begin
                    st_next.cause = item.cause_in;
                    st_next.alarm = item.alarm_in;
                end
                if (st.mode == MODE_RUN)
                begin
                    // A repeated stop restarts the settling wait from scratch.
                    st_next.last_sample   = item.encoder_count;
                    st_next.pending_pause = item.target_pause;
                    st_next.ticks         = '0;
                    st_next.stopping      = 1'b1;
                    res.first_event       = EV_STOPPING;
                end
                else
                begin
                    st_next.power   = 1'b0;
                    st_next.encoder = 1'b0;
                    if (target != st.mode)
                    begin
                        res.first_event = item.target_pause ? EV_PAUSE : EV_STOP;
                        st_next.mode    = target;
                    end
                end
            end
            OP_TICK:
            begin
                if (st.stopping)
                begin
                    if (st.last_sample != item.encoder_count)
                    begin
                        st_next.last_sample = item.encoder_count;
                        st_next.ticks       = ticks_inc;
                        done                = (ticks_inc >= timeout);
                    end
                    else
                    begin
                        done = 1'b1;
                    end
                    if (done)
                    begin
                        st_next.power    = 1'b0;
                        st_next.encoder  = 1'b0;
                        st_next.mode     = st.pending_pause ? MODE_PAUSED : MODE_STOPPED;
                        st_next.stopping = 1'b0;
                        res.first_event  = st.pending_pause ? EV_PAUSE : EV_STOP;
                        res.two_results  = 1'b1;
                    end
                end
            end
            default:
            begin
                st_next = st;
            end
        endcase
    end

endmodule

`default_nettype wire

### sv/motor_stop_supervisor.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel    Role    Payload
// req        sink    op, direction, expected count, stop target, cause, alarm, encoder
// res        source  event, last flag, enables, mode, stopping, stored status
// cfg_we     write   stop timeout in check ticks, 5 bits
//
// An item is taken and its first result is shown in the next cycle.
// A check tick that ends the stop sequence gives two results, so it holds the
// single output register until both are taken; every other item gives one.
// Reset puts the motor in the never-started state, timeout 20 ticks.
// A new item is taken while the output is empty, or while its last result is taken.

`include "motor_stop_supervisor_defines.svh"

module motor_stop_supervisor
    import mss_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    mss_req_if.sink              req,
    mss_res_if.source            res,
    input  logic                 cfg_we,
    input  logic [TIMEOUT_W-1:0] cfg_wdata
);

    state_t               st_reg;
    state_t               st_next;
    step_res_t            step_res;
    req_item_t            item;
    logic [TIMEOUT_W-1:0] timeout_reg;

    logic       res_valid_reg;
    logic       pend2_reg;
    logic [2:0] event_reg;
    logic       last_reg;
    logic       clr_reg;
    state_t     stat_reg;

    logic req_fire;
    logic res_fire;

    assign item = '{op: req.op, move_backward: req.move_backward,
                    expected_count_in: req.expected_count_in,
                    target_pause: req.target_pause, cause_in: req.cause_in,
                    alarm_in: req.alarm_in, encoder_count: req.encoder_count};

    mss_step u_step (
        .st      (st_reg),
        .item    (item),
        .timeout (timeout_reg),
        .st_next (st_next),
        .res     (step_res)
    );

    assign req.ready = !res_valid_reg || (res.ready && !pend2_reg);
    assign req_fire  = req.valid && req.ready;
    assign res_fire  = res_valid_reg && res.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= '{mode: MODE_NEVER, default: '0};
            timeout_reg   <= TIMEOUT_RESET;
            res_valid_reg <= 1'b0;
            pend2_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                timeout_reg <= cfg_wdata;
            end
            if (req_fire)
            begin
                st_reg        <= st_next;
                res_valid_reg <= 1'b1;
                pend2_reg     <= step_res.two_results;
            end
            else if (res_fire)
            begin
                if (pend2_reg)
                begin
                    pend2_reg <= 1'b0;
                end
                else
                begin
                    res_valid_reg <= 1'b0;
                end
            end
        end
    end

    // The second result of an item repeats the status, only the event and last flag change.
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            event_reg <= step_res.first_event;
            last_reg  <= !step_res.two_results;
            clr_reg   <= step_res.clear_encoder;
            stat_reg  <= st_next;
        end
        else if (res_fire && pend2_reg)
        begin
            event_reg <= EV_MOTOR_STOPPED;
            last_reg  <= 1'b1;
        end
    end

    assign res.valid          = res_valid_reg;
    assign res.event_res      = event_reg;
    assign res.last           = last_reg;
    assign res.motor_power    = stat_reg.power;
    assign res.encoder_enable = stat_reg.encoder;
    assign res.clear_encoder  = clr_reg;
    assign res.motor_mode     = stat_reg.mode;
    assign res.is_stopping    = stat_reg.stopping;
    assign res.direction_out  = stat_reg.direction;
    assign res.expected_count = stat_reg.expected;
    assign res.stop_cause     = stat_reg.cause;
    assign res.alarm_detail   = stat_reg.alarm;

    `MSS_ASSERT_NOW(a_pend_valid, pend2_reg, res_valid_reg, "second result pending with empty output")
    `MSS_ASSERT_NOW(a_pend_event, pend2_reg, (event_reg == EV_PAUSE || event_reg == EV_STOP), "second result follows a wrong event")
    `MSS_ASSERT_NEXT(a_second_result, (res_fire && pend2_reg), (res_valid_reg && last_reg && event_reg == EV_MOTOR_STOPPED), "motor stopped result missing")
    `MSS_ASSERT_NOW(a_stop_in_run, st_reg.stopping, (st_reg.mode == MODE_RUN), "stopping outside run mode")
    `MSS_ASSERT_NOW(a_enables_pair, 1'b1, (st_reg.power == st_reg.encoder), "power and encoder enables differ")

endmodule

`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import mss_pkg::*;

    typedef struct packed {
        logic [2:0]         event_code;
        logic               last;
        logic               power;
        logic               encoder;
        logic               clear;
        logic [1:0]         mode;
        logic               stopping;
        logic               direction;
        logic signed [31:0] expected;
        logic [3:0]         cause;
        logic signed [15:0] alarm;
    } status_item_t;

    // Mirrors the supervisor state and holds the results still owed by the block.
    class stop_scoreboard;
        logic [TIMEOUT_W-1:0] timeout_ticks;
        logic [1:0]           mode;
        logic                 stopping;
        logic                 direction;
        logic signed [31:0]   expected;
        logic [3:0]           cause;
        logic signed [15:0]   alarm;
        logic [31:0]          last_sample;
        logic                 pending_pause;
        logic [TICKS_W-1:0]   ticks;
        logic                 power;
        logic                 encoder;
        status_item_t         pending_results[$];
        int                   errors;
        int                   results_seen;
        int                   motor_stops;

        function new();
            timeout_ticks = TIMEOUT_RESET;
            mode = MODE_NEVER;
            stopping = 1'b0;
            direction = 1'b0;
            expected = '0;
            cause = '0;
            alarm = '0;
            last_sample = '0;
            pending_pause = 1'b0;
            ticks = '0;
            power = 1'b0;
            encoder = 1'b0;
            errors = 0;
            results_seen = 0;
            motor_stops = 0;
        endfunction

        function void note_request(req_item_t item);
            logic [2:0]   first_event;
            logic         two;
            logic         clr;
            logic         done;
            logic [1:0]   target;
            status_item_t s;
            first_event = EV_NONE;
            two = 1'b0;
            clr = 1'b0;
            case (item.op)
                OP_START:
                begin
                    if (mode != MODE_RUN || stopping)
                        first_event = EV_RUN;
                    stopping = 1'b0;
                    ticks = '0;
                    clr = 1'b1;
                    expected = item.expected_count_in;
                    direction = item.move_backward;
                    mode = MODE_RUN;
                    cause = CAUSE_USER;
                    alarm = ALARM_AFTER_START;
                    power = 1'b1;
                    encoder = 1'b1;
                end
                OP_STOP, OP_STOP_CAUSE:
                begin
                    if (item.op == OP_STOP_CAUSE)
                    begin
                        cause = item.cause_in;
                        alarm = item.alarm_in;
                    end
                    if (mode == MODE_RUN)
                    begin
                        // A stop while already stopping starts the wait again.
                        last_sample = item.encoder_count;
                        pending_pause = item.target_pause;
                        ticks = '0;
                        stopping = 1'b1;
                        first_event = EV_STOPPING;
                    end
                    else
                    begin
                        encoder = 1'b0;
                        power = 1'b0;
                        target = item.target_pause ? MODE_PAUSED : MODE_STOPPED;
                        if (target != mode)
                        begin
                            first_event = item.target_pause ? EV_PAUSE : EV_STOP;
                            mode = target;
                        end
                    end
                end
                default:
                begin
                    if (stopping)
                    begin
                        done = 1'b1;
                        if (last_sample != item.encoder_count)
                        begin
                            last_sample = item.encoder_count;
                            if (ticks < TICKS_MAX)
                                ticks = ticks + 1'b1;
                            done = (ticks >= timeout_ticks);
                        end
                        if (done)
                        begin
                            encoder = 1'b0;
                            power = 1'b0;
                            mode = pending_pause ? MODE_PAUSED : MODE_STOPPED;
                            stopping = 1'b0;
                            first_event = pending_pause ? EV_PAUSE : EV_STOP;
                            two = 1'b1;
                            motor_stops++;
                        end
                    end
                end
            endcase
            s.event_code = first_event;
            s.last = !two;
            s.power = power;
            s.encoder = encoder;
            s.clear = clr;
            s.mode = mode;
            s.stopping = stopping;
            s.direction = direction;
            s.expected = expected;
            s.cause = cause;
            s.alarm = alarm;
            pending_results.push_back(s);
            if (two)
            begin
                s.event_code = EV_MOTOR_STOPPED;
                s.last = 1'b1;
                pending_results.push_back(s);
            end
        endfunction

        function bit field_differs(string name, logic [31:0] want, logic [31:0] got);
            if (want === got)
                return 1'b0;
            if (errors < 50)
                $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
            return 1'b1;
        endfunction

        function void check_result(status_item_t got);
            status_item_t want;
            bit           bad;
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $display("%0t ns: result with no item waiting, expected none, got event %0d",
                         $time, got.event_code);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            bad = 1'b0;
            bad |= field_differs("event_res", want.event_code, got.event_code);
            bad |= field_differs("last", want.last, got.last);
            bad |= field_differs("motor_power", want.power, got.power);
            bad |= field_differs("encoder_enable", want.encoder, got.encoder);
            bad |= field_differs("clear_encoder", want.clear, got.clear);
            bad |= field_differs("motor_mode", want.mode, got.mode);
            bad |= field_differs("is_stopping", want.stopping, got.stopping);
            bad |= field_differs("direction_out", want.direction, got.direction);
            bad |= field_differs("expected_count", want.expected, got.expected);
            bad |= field_differs("stop_cause", want.cause, got.cause);
            bad |= field_differs("alarm_detail", {16'h0, want.alarm}, {16'h0, got.alarm});
            if (bad)
                errors++;
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [TIMEOUT_W-1:0] cfg_wdata;
    logic                 take_result = 1'b0;
    int                   send_idle = 30;
    int                   recv_idle = 84;
    int                   items_sent = 0;
    logic [31:0]          enc;
    stop_scoreboard       board = new();

    mss_req_if req_ch();
    mss_res_if res_ch();

    assign res_ch.ready = take_result;

    motor_stop_supervisor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin : result_monitor
        status_item_t got;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got.event_code = res_ch.event_res;
            got.last = res_ch.last;
            got.power = res_ch.motor_power;
            got.encoder = res_ch.encoder_enable;
            got.clear = res_ch.clear_encoder;
            got.mode = res_ch.motor_mode;
            got.stopping = res_ch.is_stopping;
            got.direction = res_ch.direction_out;
            got.expected = res_ch.expected_count;
            got.cause = res_ch.stop_cause;
            got.alarm = res_ch.alarm_detail;
            board.check_result(got);
        end
        take_result <= ($urandom_range(99) >= recv_idle);
    end

    function automatic req_item_t make_req(logic [1:0] op, logic backward,
                                           logic [31:0] expected, logic pause,
                                           logic [3:0] cause, logic [15:0] alarm,
                                           logic [31:0] count);
        req_item_t item;
        item.op = op;
        item.move_backward = backward;
        item.expected_count_in = expected;
        item.target_pause = pause;
        item.cause_in = cause;
        item.alarm_in = alarm;
        item.encoder_count = count;
        return item;
    endfunction

    // Fields that the operation does not use are filled with noise as well.
    function automatic req_item_t scrambled(logic [1:0] op, logic [31:0] count);
        return make_req(op, 1'($urandom), $urandom, 1'($urandom), 4'($urandom),
                        16'($urandom), count);
    endfunction

    // Called at a clock edge; returns at the edge where the item is taken, with
    // valid still high so that a following item can go out without a gap.
    task automatic push_request(req_item_t item);
        while ($urandom_range(99) < send_idle)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.op <= item.op;
        req_ch.move_backward <= item.move_backward;
        req_ch.expected_count_in <= item.expected_count_in;
        req_ch.target_pause <= item.target_pause;
        req_ch.cause_in <= item.cause_in;
        req_ch.alarm_in <= item.alarm_in;
        req_ch.encoder_count <= item.encoder_count;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        board.note_request(item);
        items_sent++;
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (board.pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_timeout(logic [TIMEOUT_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.timeout_ticks = value;
    endtask

    // Start, stop, then a random run of ticks with a moving count; it may settle or time out.
    task automatic run_stop_sequence();
        int moves;
        int i;
        push_request(scrambled(OP_START, $urandom));
        if ($urandom_range(3) == 0)
            push_request(scrambled(OP_TICK, $urandom));
        if ($urandom_range(7) == 0)
            push_request(scrambled(OP_START, $urandom));
        enc = $urandom;
        push_request(scrambled($urandom_range(1) ? OP_STOP : OP_STOP_CAUSE, enc));
        moves = ($urandom_range(9) < 5) ? $urandom_range(3) : $urandom_range(34);
        for (i = 0; i < moves; i++)
        begin
            if ($urandom_range(19) == 0)
                push_request(scrambled($urandom_range(1) ? OP_STOP : OP_STOP_CAUSE, enc));
            else
            begin
                enc = ($urandom_range(9) == 0) ? ~enc : enc + $urandom_range(1, 400);
                push_request(scrambled(OP_TICK, enc));
            end
        end
        if ($urandom_range(5) == 0)
            push_request(scrambled(OP_START, enc));
        else if ($urandom_range(3) != 0)
            push_request(scrambled(OP_TICK, enc));
    endtask

    task automatic run_segment(int quota);
        int goal;
        int kind;
        int n;
        goal = items_sent + quota;
        while (items_sent < goal)
        begin
            kind = $urandom_range(99);
            if (kind < 70)
                run_stop_sequence();
            else if (kind < 85)
            begin
                n = $urandom_range(1, 3);
                repeat (n)
                    push_request(scrambled($urandom_range(1) ? OP_STOP : OP_STOP_CAUSE,
                                           $urandom));
            end
            else
            begin
                n = $urandom_range(1, 4);
                repeat (n)
                    push_request(scrambled(2'($urandom_range(3)), $urandom));
            end
        end
    endtask

    initial
    begin : stimulus
        int seg;
        int timeout_plan[9];
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        req_ch.valid = 1'b0;
        req_ch.op = OP_START;
        req_ch.move_backward = 1'b0;
        req_ch.expected_count_in = '0;
        req_ch.target_pause = 1'b0;
        req_ch.cause_in = '0;
        req_ch.alarm_in = '0;
        req_ch.encoder_count = '0;
        timeout_plan = '{1, 31, 0, 5, 20, 2, 31, 0, 1};
        timeout_plan[8] = $urandom_range(31);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part under the reset timeout of twenty ticks.
        push_request(make_req(OP_TICK, 1'b1, 32'hFFFF_FFFF, 1'b1, 4'd15, 16'hFFFF,
                              32'hFFFF_FFFF));
        push_request(make_req(OP_STOP, 1'b0, 32'd0, 1'b0, 4'd0, 16'h0, 32'd0));
        push_request(make_req(OP_STOP, 1'b1, 32'd0, 1'b1, 4'd0, 16'h0, 32'd0));
        push_request(make_req(OP_STOP_CAUSE, 1'b0, 32'd0, 1'b1, 4'd15, 16'h8000, 32'd7));
        push_request(make_req(OP_STOP_CAUSE, 1'b0, 32'd0, 1'b0, 4'd7, 16'h7FFF, 32'd7));
        push_request(make_req(OP_START, 1'b1, 32'h8000_0000, 1'b0, 4'd0, 16'h0, 32'd0));
        push_request(make_req(OP_START, 1'b0, 32'h7FFF_FFFF, 1'b0, 4'd0, 16'h0, 32'd0));
        push_request(make_req(OP_TICK, 1'b0, 32'd0, 1'b0, 4'd0, 16'h0, 32'd123));
        push_request(make_req(OP_STOP_CAUSE, 1'b0, 32'd0, 1'b1, 4'd6, 16'hFFFF, 32'd0));
        push_request(make_req(OP_TICK, 1'b0, 32'd0, 1'b0, 4'd0, 16'h0, 32'hFFFF_FFFF));
        push_request(make_req(OP_STOP, 1'b0, 32'd0, 1'b0, 4'd0, 16'h0, 32'hFFFF_FFFF));
        push_request(make_req(OP_TICK, 1'b0, 32'd0, 1'b0, 4'd0, 16'h0, 32'hFFFF_FFFF));
        push_request(make_req(OP_TICK, 1'b0, 32'd0, 1'b0, 4'd0, 16'h0, 32'hFFFF_FFFF));
        push_request(make_req(OP_START, 1'b0, 32'd0, 1'b0, 4'd0, 16'h0, 32'd0));
        push_request(make_req(OP_STOP, 1'b0, 32'd0, 1'b1, 4'd0, 16'h0, 32'd5));
        push_request(make_req(OP_TICK, 1'b0, 32'd0, 1'b0, 4'd0, 16'h0, 32'd5));
        push_request(make_req(OP_START, 1'b1, 32'hFFFF_FFFF, 1'b0, 4'd0, 16'h0, 32'd0));
        push_request(make_req(OP_STOP_CAUSE, 1'b0, 32'd0, 1'b0, 4'd3, 16'h0, 32'd10));
        push_request(make_req(OP_START, 1'b0, 32'd42, 1'b0, 4'd0, 16'h0, 32'd10));
        push_request(make_req(OP_STOP, 1'b0, 32'd0, 1'b1, 4'd0, 16'h0, 32'd0));
        push_request(make_req(OP_TICK, 1'b0, 32'd0, 1'b0, 4'd0, 16'h0, 32'd1));
        push_request(make_req(OP_TICK, 1'b0, 32'd0, 1'b0, 4'd0, 16'h0, 32'd2));
        push_request(make_req(OP_TICK, 1'b0, 32'd0, 1'b0, 4'd0, 16'h0, 32'd2));

        // Random part: receiver-heavy idling, then sender-heavy, then none.
        for (seg = 0; seg < 9; seg++)
        begin
            send_idle = (seg < 3) ? 30 : (seg < 6) ? 84 : 0;
            recv_idle = (seg < 3) ? 84 : (seg < 6) ? 30 : 0;
            drain_results();
            write_timeout(TIMEOUT_W'(timeout_plan[seg]));
            run_segment(190);
        end
        drain_results();
        repeat (10) @(posedge clk);

        $display("Sent %0d items over nine timeout settings; checked %0d results,",
                 items_sent, board.results_seen);
        $display("of which %0d stop sequences ran to a motor stop.", board.motor_stops);
        if (board.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timed out with %0d results outstanding.", board.pending_results.size());
        $display("FAIL");
        $finish;
    end

endmodule
